@@ design/hrtm_pkg.sv @@
// hrtm_pkg: shared types, field widths and helpers for the hamming ratio test matcher
// no dependencies; imported by every module of the block but hrtm_ram
`default_nettype none

package hrtm_pkg;

    // fixed field widths of the ports
    localparam int MODE_W        = 1;
    localparam int REF_INDEX_W   = 10;
    localparam int WORD_INDEX_W  = 2;
    localparam int WORD_W        = 64;
    localparam int TAG_W         = 16;
    localparam int OCTAVE_W      = 8;
    localparam int COUNT_W       = 11;
    localparam int DIST_OUT_W    = 9;
    localparam int RATIO_W       = 9;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 11;
    localparam int POP_W         = 7;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_REFERENCE_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DISTANCE_THRESHOLD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RATIO_Q8           = 2'd2;

    // configuration reset values
    localparam logic [COUNT_W-1:0] RESET_REFERENCE_COUNT    = 11'd0;
    localparam logic [8:0]         RESET_DISTANCE_THRESHOLD = 9'd50;
    localparam logic [RATIO_W-1:0] RESET_RATIO_Q8           = 9'd204;

    // the input mode code that loads a query word
    localparam logic MODE_QUERY = 1'b1;

    // swar popcount masks
    localparam logic [WORD_W-1:0] POP_M1 = 64'h5555_5555_5555_5555;
    localparam logic [WORD_W-1:0] POP_M2 = 64'h3333_3333_3333_3333;
    localparam logic [WORD_W-1:0] POP_M4 = 64'h0F0F_0F0F_0F0F_0F0F;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic accept;   // a word is taken this cycle
        logic launch;   // the last query word is taken, search starts
        logic issue;    // read the next reference word
        logic decide;   // register the ratio product
        logic report;   // load the result registers
    } cmd_t;

    typedef struct packed {
        logic last_word;   // the word at the inputs closes a query
        logic issue_done;  // every reference word has been read
        logic pipe_empty;  // no reads still in flight
    } status_t;

    function automatic logic [POP_W-1:0] pop64(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
        a = x - ((x >> 1) & POP_M1);
        b = (a & POP_M2) + ((a >> 2) & POP_M2);
        c = (b + (b >> 4)) & POP_M4;
        d = c + (c >> 8);
        d = d + (d >> 16);
        d = d + (d >> 32);
        return d[POP_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ design/hrtm_ram.sv @@
// hrtm_ram: generic simple dual port ram, one write port and one registered read port
// depends on nothing
`default_nettype none

module hrtm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                                      clk,
    input  wire logic                                      wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic                                      rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/hrtm_ctrl.sv @@
// hrtm_ctrl: sequencing state machine of the matcher
// depends on hrtm_pkg; drives the datapath through cmd_t and reads status_t
`default_nettype none

module hrtm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire hrtm_pkg::status_t status,
    output hrtm_pkg::cmd_t         cmd,
    output logic                   busy
);

    import hrtm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy       = 1'b0;
                cmd.accept = start;
                cmd.launch = start && status.last_word;
                if (cmd.launch)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.issue = !status.issue_done;
                if (status.issue_done)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.pipe_empty)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                cmd.report = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/hrtm_datapath.sv @@
// hrtm_datapath: reference store, query words, popcount pipeline, best/second tracking
// plus ratio test and results; depends on hrtm_pkg and hrtm_ram; commanded by hrtm_ctrl
`default_nettype none

module hrtm_datapath #(
    parameter int MAX_REFERENCES       = 1024,
    parameter int WORDS_PER_DESCRIPTOR = 4
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire hrtm_pkg::cmd_t                        cmd,
    output hrtm_pkg::status_t                          status,
    input  wire logic                                  mode,
    input  wire logic [hrtm_pkg::REF_INDEX_W-1:0]      ref_index,
    input  wire logic [hrtm_pkg::WORD_INDEX_W-1:0]     word_index,
    input  wire logic [hrtm_pkg::WORD_W-1:0]           word,
    input  wire logic [hrtm_pkg::TAG_W-1:0]            query_index,
    input  wire logic signed [hrtm_pkg::OCTAVE_W-1:0]  octave,
    input  wire logic [hrtm_pkg::COUNT_W-1:0]          reference_count,
    input  wire logic [hrtm_pkg::DIST_OUT_W-1:0]       distance_threshold,
    input  wire logic [hrtm_pkg::RATIO_W-1:0]          ratio_q8,
    output logic                                       done,
    output logic [hrtm_pkg::TAG_W-1:0]                 result_query,
    output logic                                       matched,
    output logic [hrtm_pkg::REF_INDEX_W-1:0]           match_index,
    output logic [hrtm_pkg::DIST_OUT_W-1:0]            best_distance,
    output logic [hrtm_pkg::DIST_OUT_W-1:0]            second_distance,
    output logic                                       second_valid
);

    import hrtm_pkg::*;

    localparam int DEPTH = MAX_REFERENCES * WORDS_PER_DESCRIPTOR;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int WW    = WORDS_PER_DESCRIPTOR > 1 ? $clog2(WORDS_PER_DESCRIPTOR) : 1;
    localparam int SW    = MAX_REFERENCES > 1 ? $clog2(MAX_REFERENCES) : 1;
    localparam int CW    = $clog2(MAX_REFERENCES + 1);
    localparam int DW    = $clog2(WORD_W * WORDS_PER_DESCRIPTOR + 1);
    localparam int PW    = DW + RATIO_W;

    // input decode
    logic          word_ok;
    logic          ref_wr_en;
    logic [AW-1:0] ref_wr_addr;
    logic          skip;

    assign word_ok          = 32'(word_index) < WORDS_PER_DESCRIPTOR;
    assign status.last_word = (mode == MODE_QUERY) && word_ok
                              && (32'(word_index) == WORDS_PER_DESCRIPTOR - 1);
    assign ref_wr_en        = cmd.accept && (mode != MODE_QUERY) && word_ok
                              && (32'(ref_index) < MAX_REFERENCES);
    assign ref_wr_addr      = AW'(32'(ref_index) * WORDS_PER_DESCRIPTOR + 32'(word_index));
    assign skip             = !octave[OCTAVE_W-1] && (octave != '0);

    // query words
    logic [WORD_W-1:0] q_reg [WORDS_PER_DESCRIPTOR];

    always_ff @(posedge clk)
    begin
        if (cmd.accept && (mode == MODE_QUERY) && word_ok)
        begin
            q_reg[WW'(word_index)] <= word;
        end
    end

    // scan counters
    logic [AW-1:0]     rd_addr_reg;
    logic [WW-1:0]     word_cnt_reg;
    logic [CW-1:0]     slot_cnt_reg;
    logic [CW-1:0]     count_eff_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic              word_wrap;

    assign word_wrap         = 32'(word_cnt_reg) == WORDS_PER_DESCRIPTOR - 1;
    assign status.issue_done = slot_cnt_reg == count_eff_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.launch)
        begin
            rd_addr_reg  <= '0;
            word_cnt_reg <= '0;
            slot_cnt_reg <= '0;
            tag_reg      <= query_index;
            if (skip)
            begin
                count_eff_reg <= '0;
            end
            else if (32'(reference_count) > MAX_REFERENCES)
            begin
                count_eff_reg <= CW'(MAX_REFERENCES);
            end
            else
            begin
                count_eff_reg <= CW'(reference_count);
            end
        end
        else if (cmd.issue)
        begin
            rd_addr_reg <= rd_addr_reg + 1'b1;
            if (word_wrap)
            begin
                word_cnt_reg <= '0;
                slot_cnt_reg <= slot_cnt_reg + 1'b1;
            end
            else
            begin
                word_cnt_reg <= word_cnt_reg + 1'b1;
            end
        end
    end

    // reference store
    logic [WORD_W-1:0] ram_q;

    hrtm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ref_wr_en),
        .wr_addr (ref_wr_addr),
        .wr_data (word),
        .rd_en   (cmd.issue),
        .rd_addr (rd_addr_reg),
        .rd_data (ram_q)
    );

    // stage 1: ram data is out, stage 2: popcount, stage 3: slot distance
    logic              s1_v_reg;
    logic              s1_last_reg;
    logic [WW-1:0]     s1_word_reg;
    logic [SW-1:0]     s1_slot_reg;
    logic              s2_v_reg;
    logic              s2_last_reg;
    logic [SW-1:0]     s2_slot_reg;
    logic [POP_W-1:0]  s2_pop_reg;
    logic              s3_v_reg;
    logic [SW-1:0]     s3_slot_reg;
    logic [DW-1:0]     s3_dist_reg;
    logic [DW-1:0]     acc_reg;
    logic [DW-1:0]     acc_sum;

    assign acc_sum           = acc_reg + DW'(s2_pop_reg);
    assign status.pipe_empty = !s1_v_reg && !s2_v_reg && !s3_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= cmd.issue;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg && s2_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_last_reg <= word_wrap;
        s1_word_reg <= word_cnt_reg;
        s1_slot_reg <= slot_cnt_reg[SW-1:0];
        s2_last_reg <= s1_last_reg;
        s2_slot_reg <= s1_slot_reg;
        s2_pop_reg  <= pop64(ram_q ^ q_reg[s1_word_reg]);
        s3_slot_reg <= s2_slot_reg;
        s3_dist_reg <= acc_sum;
        if (cmd.launch || (s2_v_reg && s2_last_reg))
        begin
            acc_reg <= '0;
        end
        else if (s2_v_reg)
        begin
            acc_reg <= acc_sum;
        end
    end

    // best and second best
    logic              have_best_reg;
    logic              have_second_reg;
    logic [DW-1:0]     best_reg;
    logic [DW-1:0]     second_reg;
    logic [SW-1:0]     best_slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_best_reg   <= 1'b0;
            have_second_reg <= 1'b0;
        end
        else if (cmd.launch)
        begin
            have_best_reg   <= 1'b0;
            have_second_reg <= 1'b0;
        end
        else if (s3_v_reg)
        begin
            if (!have_best_reg || (s3_dist_reg < best_reg))
            begin
                have_best_reg   <= 1'b1;
                have_second_reg <= have_best_reg;
            end
            else
            begin
                have_second_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_v_reg)
        begin
            if (!have_best_reg || (s3_dist_reg < best_reg))
            begin
                second_reg    <= best_reg;
                best_reg      <= s3_dist_reg;
                best_slot_reg <= s3_slot_reg;
            end
            else if (!have_second_reg || (s3_dist_reg < second_reg))
            begin
                second_reg <= s3_dist_reg;
            end
        end
    end

    // ratio test
    logic [PW-1:0] prod_reg;
    logic          ratio_ok;
    logic          match_next;

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            prod_reg <= PW'(second_reg) * PW'(ratio_q8);
        end
    end

    assign ratio_ok   = have_second_reg ? (PW'({best_reg, 8'b0}) < prod_reg)
                                        : (ratio_q8 != '0);
    assign match_next = have_best_reg && (32'(best_reg) <= 32'(distance_threshold))
                        && ratio_ok;

    // result registers
    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.report;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.report)
        begin
            result_query    <= tag_reg;
            matched         <= match_next;
            match_index     <= have_best_reg ? REF_INDEX_W'(best_slot_reg) : '0;
            best_distance   <= have_best_reg ? DIST_OUT_W'(best_reg) : '0;
            second_distance <= have_second_reg ? DIST_OUT_W'(second_reg) : '0;
            second_valid    <= have_second_reg;
        end
    end

    assign done = done_reg;

    a_second_needs_best: assert property (@(posedge clk) disable iff (!rst_n)
        have_second_reg |-> have_best_reg)
        else $error("second best held without a best");

    a_order_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (have_second_reg && have_best_reg) |-> (second_reg >= best_reg))
        else $error("second best below best");

    a_decide_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide |-> (status.pipe_empty && status.issue_done))
        else $error("ratio test taken with reads in flight");

    a_launch_clean: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.launch |-> status.pipe_empty)
        else $error("search launched over a running scan");

endmodule

`default_nettype wire

@@ design/hamming_ratio_test_matcher_unit.sv @@
// hamming_ratio_test_matcher_unit: top level, configuration registers and the two halves
// depends on hrtm_pkg, hrtm_ctrl, hrtm_datapath (which holds hrtm_ram)
//
//   channel   direction  handshake              word
//   input     in         start / busy           mode, ref_index, word_index, word,
//                                               query_index, octave
//   config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//   result    out        done strobe            result_query, matched, match_index,
//                                               best_distance, second_distance, second_valid
//
// a reference word or a middle query word is taken with busy staying low
// the last query word holds busy while the store is read, one read per word of each of the
// first n references, n being reference_count capped at MAX_REFERENCES (no reads when n is 0
// or the octave is skipped); done pulses in the cycle in which busy falls
// rst_n clears control and loads the register defaults; the store holds no reset value
// configuration words are always taken (cfg_ready is tied high); results cannot be stalled
`default_nettype none

module hamming_ratio_test_matcher_unit #(
    parameter int MAX_REFERENCES       = 1024,
    parameter int WORDS_PER_DESCRIPTOR = 4
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic                                  mode,
    input  wire logic [hrtm_pkg::REF_INDEX_W-1:0]      ref_index,
    input  wire logic [hrtm_pkg::WORD_INDEX_W-1:0]     word_index,
    input  wire logic [hrtm_pkg::WORD_W-1:0]           word,
    input  wire logic [hrtm_pkg::TAG_W-1:0]            query_index,
    input  wire logic signed [hrtm_pkg::OCTAVE_W-1:0]  octave,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [hrtm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [hrtm_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                       done,
    output logic [hrtm_pkg::TAG_W-1:0]                 result_query,
    output logic                                       matched,
    output logic [hrtm_pkg::REF_INDEX_W-1:0]           match_index,
    output logic [hrtm_pkg::DIST_OUT_W-1:0]            best_distance,
    output logic [hrtm_pkg::DIST_OUT_W-1:0]            second_distance,
    output logic                                       second_valid
);

    import hrtm_pkg::*;

    logic [COUNT_W-1:0]    count_reg;
    logic [DIST_OUT_W-1:0] threshold_reg;
    logic [RATIO_W-1:0]    ratio_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= RESET_REFERENCE_COUNT;
            threshold_reg <= RESET_DISTANCE_THRESHOLD;
            ratio_reg     <= RESET_RATIO_Q8;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // unknown indexes are dropped
            unique case (cfg_index)
                REG_REFERENCE_COUNT:    count_reg     <= COUNT_W'(cfg_data);
                REG_DISTANCE_THRESHOLD: threshold_reg <= DIST_OUT_W'(cfg_data);
                REG_RATIO_Q8:           ratio_reg     <= RATIO_W'(cfg_data);
                default:                ;
            endcase
        end
    end

    cmd_t    cmd;
    status_t status;

    hrtm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    hrtm_datapath #(
        .MAX_REFERENCES       (MAX_REFERENCES),
        .WORDS_PER_DESCRIPTOR (WORDS_PER_DESCRIPTOR)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .mode               (mode),
        .ref_index          (ref_index),
        .word_index         (word_index),
        .word               (word),
        .query_index        (query_index),
        .octave             (octave),
        .reference_count    (count_reg),
        .distance_threshold (threshold_reg),
        .ratio_q8           (ratio_reg),
        .done               (done),
        .result_query       (result_query),
        .matched            (matched),
        .match_index        (match_index),
        .best_distance      (best_distance),
        .second_distance    (second_distance),
        .second_valid       (second_valid)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_hamming_ratio_test_matcher_unit.sv @@
// testbench for hamming_ratio_test_matcher_unit: a scoreboard class that predicts each search
// result and checks it, plus tasks that load references, queries and registers
// depends on hrtm_pkg and the hamming_ratio_test_matcher_unit rtl
`timescale 1ns / 100ps

import hrtm_pkg::*;

localparam int NUM_SLOTS     = 1024;
localparam int DESC_WORDS    = 4;
localparam int PRELOAD_SLOTS = 12;

localparam logic                    MODE_REFERENCE = 1'b0;
localparam logic [WORD_INDEX_W-1:0] LAST_WORD      = WORD_INDEX_W'(DESC_WORDS - 1);
localparam logic [CFG_INDEX_W-1:0]  REG_UNUSED     = 2'd3;

typedef logic [DESC_WORDS-1:0][WORD_W-1:0] desc_t;

typedef struct packed {
    logic                            mode;
    logic [REF_INDEX_W-1:0]          ref_index;
    logic [WORD_INDEX_W-1:0]         word_index;
    logic [WORD_W-1:0]               word;
    logic [TAG_W-1:0]                query_index;
    logic signed [OCTAVE_W-1:0]      octave;
} word_item_t;

typedef struct packed {
    logic [TAG_W-1:0]                query;
    logic                            hit;
    logic [REF_INDEX_W-1:0]          slot;
    logic [DIST_OUT_W-1:0]           best;
    logic [DIST_OUT_W-1:0]           second;
    logic                            second_ok;
} match_t;

class match_scoreboard;
    logic [WORD_W-1:0] refs [NUM_SLOTS*DESC_WORDS];
    desc_t             query;
    int unsigned       ref_count;
    int unsigned       threshold;
    int unsigned       ratio;
    match_t            pending_matches [$];
    int unsigned       mismatches;
    int unsigned       results;
    int unsigned       matched_count;
    int unsigned       skipped;

    function new();
        ref_count = RESET_REFERENCE_COUNT;
        threshold = RESET_DISTANCE_THRESHOLD;
        ratio     = RESET_RATIO_Q8;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_REFERENCE_COUNT:    ref_count = data;
            REG_DISTANCE_THRESHOLD: threshold = data[8:0];
            REG_RATIO_Q8:           ratio = data[RATIO_W-1:0];
            default: ;
        endcase
    endfunction

    function int unsigned active_slots();
        return (ref_count > NUM_SLOTS) ? NUM_SLOTS : ref_count;
    endfunction

    function int unsigned distance_to(int unsigned slot);
        int unsigned d;
        d = 0;
        for (int w = 0; w < DESC_WORDS; w++)
            d += $countones(query[w] ^ refs[slot*DESC_WORDS + w]);
        return d;
    endfunction

    // one accepted word: update the mirrored state, predict a result on the last query word
    function void note_word(word_item_t it);
        int unsigned d;
        int unsigned best;
        int unsigned second;
        int unsigned best_slot;
        bit          have_best;
        bit          have_second;
        bit          hit;
        match_t      m;
        if (it.mode != MODE_QUERY)
        begin
            refs[int'(it.ref_index)*DESC_WORDS + int'(it.word_index)] = it.word;
            return;
        end
        query[it.word_index] = it.word;
        if (it.word_index != LAST_WORD)
            return;
        best = 0;
        second = 0;
        best_slot = 0;
        have_best = 0;
        have_second = 0;
        hit = 0;
        if (it.octave[OCTAVE_W-1] || it.octave == '0)
        begin
            for (int unsigned s = 0; s < active_slots(); s++)
            begin
                d = distance_to(s);
                if (!have_best || d < best)
                begin
                    if (have_best)
                    begin
                        second = best;
                        have_second = 1;
                    end
                    best = d;
                    best_slot = s;
                    have_best = 1;
                end
                else if (!have_second || d < second)
                begin
                    second = d;
                    have_second = 1;
                end
            end
            if (have_best && best <= threshold)
                hit = have_second ? (best * 256 < second * ratio) : (ratio > 0);
        end
        else
            skipped++;
        m.query     = it.query_index;
        m.hit       = hit;
        m.slot      = REF_INDEX_W'(best_slot);
        m.best      = DIST_OUT_W'(best);
        m.second    = DIST_OUT_W'(second);
        m.second_ok = have_second;
        pending_matches.push_back(m);
    endfunction

    task report_mismatch(string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task compare_field(string field, logic [TAG_W-1:0] tag, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("query %h: %s is %0h, expected %0h", tag, field, got, want));
    endtask

    task check_match(match_t got);
        match_t want;
        results++;
        if (got.hit === 1'b1)
            matched_count++;
        if (pending_matches.size() == 0)
        begin
            report_mismatch($sformatf("result for query %h with no search pending", got.query));
            return;
        end
        want = pending_matches.pop_front();
        compare_field("result_query", want.query, got.query, want.query);
        compare_field("matched", want.query, got.hit, want.hit);
        compare_field("match_index", want.query, got.slot, want.slot);
        compare_field("best_distance", want.query, got.best, want.best);
        compare_field("second_distance", want.query, got.second, want.second);
        compare_field("second_valid", want.query, got.second_ok, want.second_ok);
    endtask
endclass

module tb_hamming_ratio_test_matcher_unit;

    localparam int LIMIT_CYCLES = 500_000;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic                        mode;
    logic [REF_INDEX_W-1:0]      ref_index;
    logic [WORD_INDEX_W-1:0]     word_index;
    logic [WORD_W-1:0]           word;
    logic [TAG_W-1:0]            query_index;
    logic signed [OCTAVE_W-1:0]  octave;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_INDEX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;
    logic                        done;
    logic [TAG_W-1:0]            result_query;
    logic                        matched;
    logic [REF_INDEX_W-1:0]      match_index;
    logic [DIST_OUT_W-1:0]       best_distance;
    logic [DIST_OUT_W-1:0]       second_distance;
    logic                        second_valid;

    match_scoreboard book;
    bit              idling;
    int unsigned     words_sent;
    int unsigned     reg_writes;
    int unsigned     cycles;

    hamming_ratio_test_matcher_unit #(
        .MAX_REFERENCES       (NUM_SLOTS),
        .WORDS_PER_DESCRIPTOR (DESC_WORDS)
    ) DUT (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("hamming_ratio_test_matcher_unit regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            book.check_match(match_t'({result_query, matched, match_index, best_distance,
                                        second_distance, second_valid}));
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic desc_t random_desc();
        desc_t d;
        for (int w = 0; w < DESC_WORDS; w++)
            d[w] = rand_word();
        return d;
    endfunction

    function automatic desc_t perturb(desc_t d, int unsigned flips);
        for (int unsigned i = 0; i < flips; i++)
            d[$urandom_range(0, DESC_WORDS-1)][$urandom_range(0, WORD_W-1)] ^= 1'b1;
        return d;
    endfunction

    function automatic desc_t slot_desc(int unsigned slot);
        desc_t d;
        for (int w = 0; w < DESC_WORDS; w++)
            d[w] = book.refs[slot*DESC_WORDS + w];
        return d;
    endfunction

    function automatic logic signed [OCTAVE_W-1:0] pick_octave();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return '0;
        if (r < 7)
            return OCTAVE_W'(-int'($urandom_range(1, 128)));
        if (r < 9)
            return OCTAVE_W'($urandom_range(1, 127));
        return OCTAVE_W'($urandom);
    endfunction

    function automatic word_item_t pack_word(logic m, logic [REF_INDEX_W-1:0] ri,
                                             logic [WORD_INDEX_W-1:0] wi, logic [WORD_W-1:0] w,
                                             logic [TAG_W-1:0] tag,
                                             logic signed [OCTAVE_W-1:0] oct);
        word_item_t it;
        it.mode        = m;
        it.ref_index   = ri;
        it.word_index  = wi;
        it.word        = w;
        it.query_index = tag;
        it.octave      = oct;
        return it;
    endfunction

    // start stays high after the word is taken; the next call or a pause lowers or reloads it
    task automatic send_word(input word_item_t it);
        @(negedge clk);
        start       = 1'b1;
        mode        = it.mode;
        ref_index   = it.ref_index;
        word_index  = it.word_index;
        word        = it.word;
        query_index = it.query_index;
        octave      = it.octave;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        book.note_word(it);
        words_sent++;
    endtask

    task automatic maybe_idle();
        if (idling && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat ($urandom_range(0, 4))
                @(negedge clk);
        end
    endtask

    task automatic send_query(input desc_t d, input logic [TAG_W-1:0] tag,
                              input logic signed [OCTAVE_W-1:0] oct, input bit broken);
        for (int w = 0; w < DESC_WORDS; w++)
        begin
            // a broken query drops some of its leading words and reuses stale ones
            if (!broken || w == DESC_WORDS - 1 || $urandom_range(0, 1) == 1)
            begin
                maybe_idle();
                send_word(pack_word(MODE_QUERY, REF_INDEX_W'($urandom), WORD_INDEX_W'(w),
                                    d[w], tag, oct));
            end
        end
    endtask

    task automatic send_reference(input int unsigned slot, input int unsigned w,
                                  input logic [WORD_W-1:0] value);
        maybe_idle();
        send_word(pack_word(MODE_REFERENCE, REF_INDEX_W'(slot), WORD_INDEX_W'(w), value,
                            TAG_W'($urandom), OCTAVE_W'($urandom)));
    endtask

    // block idle: lower start, then wait until no search is pending and busy is low
    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        while (book.pending_matches.size() != 0 || busy)
            @(negedge clk);
        repeat (8)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        start     = 1'b0;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        book.set_register(idx, data);
        reg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] count_val,
                             input logic [CFG_DATA_W-1:0] thr_val,
                             input logic [CFG_DATA_W-1:0] ratio_val);
        settle();
        write_reg(REG_REFERENCE_COUNT, count_val);
        write_reg(REG_DISTANCE_THRESHOLD, thr_val);
        write_reg(REG_RATIO_Q8, ratio_val);
    endtask

    initial
    begin
        desc_t       anchor;
        desc_t       probe;
        int unsigned phase;
        int unsigned budget;
        int unsigned phase_base;
        int unsigned rand_base;
        int unsigned result_base;
        int unsigned pick;
        int unsigned eff;
        int unsigned src;
        int unsigned dst;
        int unsigned wsel;
        int unsigned flips;
        logic [CFG_DATA_W-1:0] cnt;
        logic [CFG_DATA_W-1:0] thr;
        logic [CFG_DATA_W-1:0] rat;

        book        = new();
        rst_n       = 1'b0;
        start       = 1'b0;
        mode        = MODE_REFERENCE;
        ref_index   = '0;
        word_index  = '0;
        word        = '0;
        query_index = '0;
        octave      = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_REFERENCE_COUNT;
        cfg_data    = '0;
        idling      = 1;
        words_sent  = 0;
        reg_writes  = 0;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings search nothing; octave above zero skips, negative octaves do not
        anchor = random_desc();
        send_query(anchor, 16'h0000, 8'sd0, 0);
        send_word(pack_word(MODE_QUERY, 10'h3FF, LAST_WORD, ~anchor[DESC_WORDS-1], 16'hFFFF,
                            8'sd127));
        send_word(pack_word(MODE_QUERY, 10'h000, LAST_WORD, anchor[DESC_WORDS-1], 16'h8001,
                            8'sh80));
        send_word(pack_word(MODE_QUERY, 10'h155, LAST_WORD, anchor[DESC_WORDS-1], 16'h7FFE,
                            8'sd1));

        // leading slots loaded here; every search stays within them
        for (int unsigned s = 0; s < PRELOAD_SLOTS; s++)
        begin
            case (s)
                0, 1:    probe = anchor;
                2:       probe = ~anchor;
                3:       probe = perturb(anchor, 12);
                4:       probe = '0;
                5:       probe = '1;
                default: probe = random_desc();
            endcase
            for (int w = 0; w < DESC_WORDS; w++)
                send_reference(s, w, probe[w]);
        end

        // tie at distance zero fails the ratio test
        configure(11'd4, 11'd256, 11'd256);
        send_query(anchor, 16'h0001, 8'sd0, 0);
        // single candidate at the full distance
        configure(11'd1, 11'd256, 11'd256);
        send_query(~anchor, 16'h0002, -8'sd1, 0);
        configure(11'd1, 11'd255, 11'd0);
        send_query(~anchor, 16'h0003, 8'sd0, 0);
        send_query(anchor, 16'h0004, 8'sd0, 0);
        configure(11'd3, 11'd255, 11'd256);
        send_query(~anchor, 16'h0005, 8'sd0, 0);

        phase       = 0;
        rand_base   = words_sent;
        result_base = book.results;
        while (words_sent - rand_base < 64 || book.results - result_base < 16)
        begin
            case (phase)
                0:
                begin
                    cnt = CFG_DATA_W'(PRELOAD_SLOTS); thr = 11'd256; rat = 11'd256;
                    budget = 20;
                end
                1:
                begin
                    cnt = CFG_DATA_W'(PRELOAD_SLOTS); thr = 11'd64;  rat = 11'd204;
                    budget = 8;
                end
                2:
                begin
                    // ratio keeps its low nine bits
                    cnt = 11'd5;    thr = 11'd0;   rat = 11'h500; budget = 8;
                end
                3:
                begin
                    cnt = 11'd0;    thr = CFG_DATA_W'($urandom_range(0, 256));
                    rat = 11'd0;    budget = 10;
                end
                default:
                begin
                    cnt = CFG_DATA_W'($urandom_range(1, PRELOAD_SLOTS));
                    thr = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 256))
                                                      : CFG_DATA_W'($urandom_range(20, 110));
                    rat = CFG_DATA_W'($urandom_range(0, 256));
                    budget = 12;
                end
            endcase
            configure(cnt, thr, rat);
            if (phase == 3)
                write_reg(REG_UNUSED, 11'h7FF);
            eff = book.active_slots();
            phase_base = words_sent;
            while (words_sent - phase_base < budget)
            begin
                if (words_sent - rand_base >= 48)
                    idling = 0;
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    src = (eff == 0) ? $urandom_range(0, PRELOAD_SLOTS-1)
                                     : $urandom_range(0, eff-1);
                    flips = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 90)
                                                        : $urandom_range(0, 24);
                    probe = perturb(slot_desc(src), flips);
                    send_query(probe, TAG_W'($urandom), pick_octave(),
                               $urandom_range(0, 9) == 0);
                end
                else if (pick < 72)
                    send_query(random_desc(), TAG_W'($urandom), OCTAVE_W'($urandom), 0);
                else if (pick < 87)
                begin
                    src = (eff == 0) ? $urandom_range(0, PRELOAD_SLOTS-1)
                                     : $urandom_range(0, eff-1);
                    dst = (eff == 0 || $urandom_range(0, 4) == 0)
                          ? $urandom_range(0, NUM_SLOTS-1) : $urandom_range(0, eff-1);
                    probe = slot_desc(src);
                    if ($urandom_range(0, 2) == 0)
                    begin
                        // duplicate descriptor makes tied distances
                        for (int w = 0; w < DESC_WORDS; w++)
                            send_reference(dst, w, probe[w]);
                    end
                    else
                    begin
                        wsel = $urandom_range(0, DESC_WORDS-1);
                        probe = perturb(probe, $urandom_range(0, 8));
                        send_reference(dst, wsel,
                                       $urandom_range(0, 1) ? probe[wsel] : rand_word());
                    end
                end
                else
                begin
                    maybe_idle();
                    send_word(pack_word(MODE_QUERY, REF_INDEX_W'($urandom),
                                        WORD_INDEX_W'($urandom_range(0, DESC_WORDS-1)),
                                        rand_word(), TAG_W'($urandom), pick_octave()));
                end
            end
            phase++;
        end

        settle();
        repeat (16)
            @(negedge clk);
        if (book.pending_matches.size() != 0)
            book.report_mismatch($sformatf("%0d results never arrived",
                                           book.pending_matches.size()));
        $display("covered %0d words in, %0d results (%0d matched, %0d skipped by octave)",
                 words_sent, book.results, book.matched_count, book.skipped);
        $display("%0d register writes; searches ran empty and small, with ties, both ends",
                 reg_writes);
        if (book.mismatches == 0)
            $display("hamming_ratio_test_matcher_unit regression: pass");
        else
            $display("hamming_ratio_test_matcher_unit regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
design/hrtm_pkg.sv
design/hrtm_ram.sv
design/hrtm_ctrl.sv
design/hrtm_datapath.sv
design/hamming_ratio_test_matcher_unit.sv
tb/sv/tb_hamming_ratio_test_matcher_unit.sv
